// ===== hdl/lzss_pkg.sv =====
// Shared types and constants for the LZSS bitstream decoder.
package lzss_pkg;

  localparam int unsigned HIST_DEPTH = 4096;
  localparam int unsigned ADDR_W     = $clog2(HIST_DEPTH);
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned LIT_BITS   = 8;
  localparam int unsigned LEN_BITS   = 4;
  localparam int unsigned DIST_BITS  = 12;
  localparam int unsigned MIN_COPY   = 3;
  localparam int unsigned LIT_TOKEN  = 1 + LIT_BITS;
  localparam int unsigned COPY_TOKEN = 1 + LEN_BITS + DIST_BITS;
  localparam int unsigned BUF_W      = COPY_TOKEN - 1 + WORD_BITS;
  localparam int unsigned CNT_W      = $clog2(BUF_W + 1);
  localparam int unsigned LEFT_W     = LEN_BITS + 1;
  localparam int unsigned SIZE_W     = 32;

  typedef struct packed {
    logic [WORD_BITS-1:0] stream_word;
    logic                 start_stream;
  } in_item_t;

  typedef struct packed {
    logic [LIT_BITS-1:0] out_byte;
    logic                last_of_word;
    logic                stream_done;
  } out_item_t;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_DECODE = 6'b000100,
    S_READ   = 6'b001000,
    S_COPY   = 6'b010000,
    S_FLUSH  = 6'b100000
  } dec_state_t;

endpackage

// ===== hdl/lzss_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module lzss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/lzss_bitstream_decoder.sv =====
// Top level of the LZSS bitstream decoder: token sequencer, history ring and output stage.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall  | stream_word, start_stream
//   out_    | output    | out_valid / out_stall| out_byte, last_of_word, stream_done
//   cfg_    | input     | cfg_wr_en            | cfg_wr_data (total_size)
//
// A word is accepted in S_IDLE, decoded in S_DECODE and closed in S_FLUSH. Each copied
// byte passes S_READ then S_COPY, since it reads the history RAM and then writes it back
// through its single ports. A dropped word is accepted and discarded, staying in S_IDLE.
// After reset a clearing pass writes zeros to all 4096 history entries, one per cycle,
// and no word is accepted during it; configuration writes are taken at any time.
// Reset is synchronous and active low. A stalled output holds the sequencer only when
// both the output register and the pending byte are full.
module lzss_bitstream_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lzss_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lzss_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data
);
  import lzss_pkg::*;

  dec_state_t           state_r, state_nxt;
  logic [SIZE_W-1:0]    total_r;
  logic [BUF_W-1:0]     buf_r, buf_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]    wp_r, wp_nxt;
  logic [ADDR_W-1:0]    clr_r, clr_nxt;
  logic [SIZE_W-1:0]    bytes_r, bytes_nxt;
  logic                 done_r, done_nxt;
  logic [DIST_BITS-1:0] dist_r, dist_nxt;
  logic [LEFT_W-1:0]    left_r, left_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  out_item_t            pend_r, pend_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_r, out_nxt;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_wa;
  logic [LIT_BITS-1:0]  ram_wd;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_ra;
  logic [LIT_BITS-1:0]  ram_rd;

  logic                 emit;
  logic [LIT_BITS-1:0]  emit_byte;
  logic [SIZE_W-1:0]    bytes_inc;
  logic                 hit_total;
  logic                 out_free;
  logic                 emit_ok;
  logic                 in_xfer;
  logic [SIZE_W-1:0]    bytes_eff;
  logic                 done_eff;
  logic [BUF_W-1:0]     buf_eff;
  logic [CNT_W-1:0]     cnt_eff;

  lzss_ram #(
    .WIDTH (LIT_BITS),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_ok   = !pend_valid_r || out_free;
  assign bytes_inc = bytes_r + SIZE_W'(1);
  assign hit_total = (bytes_inc == total_r);

  assign bytes_eff = in_data.start_stream ? '0 : bytes_r;
  assign done_eff  = in_data.start_stream ? 1'b0 : done_r;
  assign buf_eff   = in_data.start_stream ? '0 : buf_r;
  assign cnt_eff   = in_data.start_stream ? '0 : cnt_r;

  always_comb begin
    state_nxt      = state_r;
    buf_nxt        = buf_r;
    cnt_nxt        = cnt_r;
    wp_nxt         = wp_r;
    clr_nxt        = clr_r;
    bytes_nxt      = bytes_r;
    done_nxt       = done_r;
    dist_nxt       = dist_r;
    left_nxt       = left_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    ram_we         = 1'b0;
    ram_wa         = wp_r;
    ram_wd         = '0;
    ram_re         = 1'b0;
    ram_ra         = wp_r - dist_r[ADDR_W-1:0];
    emit           = 1'b0;
    emit_byte      = '0;

    unique case (state_r)
      S_CLEAR: begin
        ram_we  = 1'b1;
        ram_wa  = clr_r;
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(HIST_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          bytes_nxt = bytes_eff;
          done_nxt  = done_eff;
          buf_nxt   = buf_eff;
          cnt_nxt   = cnt_eff;
          if (!done_eff && (bytes_eff < total_r)) begin
            buf_nxt   = buf_eff | (BUF_W'(in_data.stream_word) << cnt_eff);
            cnt_nxt   = cnt_eff + CNT_W'(WORD_BITS);
            state_nxt = S_DECODE;
          end
        end
      end
      S_DECODE: begin
        priority if (bytes_r >= total_r || cnt_r == '0) begin
          state_nxt = S_FLUSH;
        end else if (!buf_r[0]) begin
          if (cnt_r < CNT_W'(LIT_TOKEN)) begin
            state_nxt = S_FLUSH;
          end else if (emit_ok) begin
            emit      = 1'b1;
            emit_byte = buf_r[LIT_BITS:1];
            buf_nxt   = buf_r >> LIT_TOKEN;
            cnt_nxt   = cnt_r - CNT_W'(LIT_TOKEN);
          end
        end else begin
          if (cnt_r < CNT_W'(COPY_TOKEN)) begin
            state_nxt = S_FLUSH;
          end else begin
            left_nxt  = LEFT_W'(buf_r[LEN_BITS:1]) + LEFT_W'(MIN_COPY);
            dist_nxt  = buf_r[COPY_TOKEN-1:LEN_BITS+1];
            buf_nxt   = buf_r >> COPY_TOKEN;
            cnt_nxt   = cnt_r - CNT_W'(COPY_TOKEN);
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        if (bytes_r >= total_r || left_r == '0) begin
          state_nxt = S_DECODE;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_byte = ram_rd;
          left_nxt  = left_r - LEFT_W'(1);
          state_nxt = S_READ;
        end
      end
      S_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt              = pend_r;
          out_nxt.last_of_word = 1'b1;
          pend_valid_nxt       = 1'b0;
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    if (emit) begin
      ram_we    = 1'b1;
      ram_wa    = wp_r;
      ram_wd    = emit_byte;
      wp_nxt    = wp_r + ADDR_W'(1);
      bytes_nxt = bytes_inc;
      if (hit_total) begin
        done_nxt = 1'b1;
      end
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = pend_r;
      end
      pend_valid_nxt        = 1'b1;
      pend_nxt.out_byte     = emit_byte;
      pend_nxt.last_of_word = 1'b0;
      pend_nxt.stream_done  = hit_total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      total_r      <= '0;
      buf_r        <= '0;
      cnt_r        <= '0;
      wp_r         <= '0;
      clr_r        <= '0;
      bytes_r      <= '0;
      done_r       <= 1'b0;
      left_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_wr_en) begin
        total_r <= cfg_wr_data;
      end
      buf_r        <= buf_nxt;
      cnt_r        <= cnt_nxt;
      wp_r         <= wp_nxt;
      clr_r        <= clr_nxt;
      bytes_r      <= bytes_nxt;
      done_r       <= done_nxt;
      left_r       <= left_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(BUF_W))
    else $error("bit count exceeds buffer width");

  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= LEFT_W'((1 << LEN_BITS) - 1 + MIN_COPY))
    else $error("copy length out of range");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_valid_r)
    else $error("pending byte left behind at end of word");

  a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
    emit && hit_total |=> done_r && pend_valid_r && pend_r.stream_done)
    else $error("final byte did not set the done flag");
`endif

endmodule
